### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. Every macro samples on clk and is
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### hdl/les_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_pkg
// Shared constants, effect codes and the result type of the LED effect
// sequencer.
// ----------------------------------------------------------------------------
package les_pkg;

    // Row width and derived masks
    localparam int LED_COUNT = 16;

    localparam logic [LED_COUNT-1:0] ROW_MASK = {LED_COUNT{1'b1}};
    localparam logic [LED_COUNT-1:0] TOP_BIT  = {1'b1, {(LED_COUNT-1){1'b0}}};
    localparam logic [LED_COUNT-1:0] LOW_HALF =
        LED_COUNT'((64'd1 << (LED_COUNT / 2)) - 64'd1);
    localparam logic [LED_COUNT-1:0] HIGH_HALF = ROW_MASK & ~LOW_HALF;
    localparam logic [LED_COUNT-1:0] ALT_BITS  = LED_COUNT'(32'hAAAA_AAAA);
    localparam logic [4:0]           LAST_POS  = 5'(LED_COUNT - 1);

    // Effect codes
    localparam logic [3:0] EFF_BLINK_ALL    = 4'd0;
    localparam logic [3:0] EFF_FILL_RIGHT   = 4'd1;
    localparam logic [3:0] EFF_CLEAR_RIGHT  = 4'd2;
    localparam logic [3:0] EFF_FILL_LEFT    = 4'd3;
    localparam logic [3:0] EFF_CLEAR_LEFT   = 4'd4;
    localparam logic [3:0] EFF_ALTERNATE    = 4'd5;
    localparam logic [3:0] EFF_BLINK_HALVES = 4'd6;
    localparam logic [3:0] EFF_STACK_UP     = 4'd7;
    localparam logic [3:0] EFF_STACK_DOWN   = 4'd8;
    localparam logic [3:0] EFF_SPLIT_BLINK  = 4'd9;

    // Configuration register map (word select bit of paddr)
    localparam logic       REG_BLINK_FRAMES = 1'b0;
    localparam logic [4:0] BLINK_RESET      = 5'd10;

    // One result frame
    typedef struct packed {
        logic [15:0] led_pattern;
        logic [3:0]  effect_number;
        logic        cycle_end;
    } frame_t;

endpackage

### hdl/les_tick_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_tick_if
// Tick request channel: valid/ready handshake with the advance bit.
// ----------------------------------------------------------------------------
interface les_tick_if;
    logic valid;
    logic ready;
    logic advance;

    modport source (output valid, output advance, input ready);
    modport sink   (input valid, input advance, output ready);
endinterface

### hdl/les_frame_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_frame_if
// Frame request channel: valid/ready handshake with the frame fields.
// ----------------------------------------------------------------------------
interface les_frame_if;
    logic        valid;
    logic        ready;
    logic [15:0] led_pattern;
    logic [3:0]  effect_number;
    logic        cycle_end;

    modport source (output valid, output led_pattern, output effect_number,
                    output cycle_end, input ready);
    modport sink   (input valid, input led_pattern, input effect_number,
                    input cycle_end, output ready);
endinterface

### hdl/les_frame_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_frame_gen
// Effect state registers and next-frame logic. Presents the frame held now
// and steps to the next one when a tick with advance set is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module les_frame_gen
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [4:0]           blink_frames,
    input  logic                 step,
    input  logic                 advance,
    output les_pkg::frame_t      result
);

    localparam int W = les_pkg::LED_COUNT;

    logic [3:0]   effect_reg,  effect_next;
    logic [4:0]   inner_reg,   inner_next;
    logic [4:0]   outer_reg,   outer_next;
    logic [W-1:0] frame_reg,   frame_next;
    logic [W-1:0] stacked_reg, stacked_next;
    logic [W-1:0] dot_reg,     dot_next;

    logic [5:0]   blink_len;
    logic         blink_last;
    logic         is_last;
    logic [3:0]   effect_succ;
    logic [4:0]   inner_inc;
    logic [4:0]   outer_inc;
    logic [W-1:0] dot_adv;

    assign blink_len  = (blink_frames == 5'd0) ? 6'd1 : {1'b0, blink_frames};
    assign blink_last = ({1'b0, inner_reg} + 6'd1) >= blink_len;
    assign inner_inc  = inner_reg + 5'd1;
    assign outer_inc  = outer_reg + 5'd1;

    always_comb
    begin
        unique case (effect_reg)
            les_pkg::EFF_BLINK_ALL, les_pkg::EFF_ALTERNATE, les_pkg::EFF_BLINK_HALVES:
                is_last = blink_last;
            les_pkg::EFF_FILL_RIGHT, les_pkg::EFF_CLEAR_RIGHT,
            les_pkg::EFF_FILL_LEFT, les_pkg::EFF_CLEAR_LEFT:
                is_last = inner_reg >= les_pkg::LAST_POS;
            les_pkg::EFF_STACK_UP, les_pkg::EFF_STACK_DOWN:
                is_last = (outer_reg >= les_pkg::LAST_POS) && (inner_reg >= les_pkg::LAST_POS);
            les_pkg::EFF_SPLIT_BLINK:
                is_last = (outer_reg != 5'd0) && blink_last;
            default:
                is_last = 1'b1;
        endcase
    end

    // Wrap to the first effect after the last one, or from a stray code
    assign effect_succ = (effect_reg >= les_pkg::EFF_SPLIT_BLINK) ? les_pkg::EFF_BLINK_ALL
                                                                  : effect_reg + 4'd1;

    assign dot_adv = (effect_reg == les_pkg::EFF_STACK_UP) ? ((dot_reg << 1) & les_pkg::ROW_MASK)
                                                           : (dot_reg >> 1);

    always_comb
    begin
        effect_next  = effect_reg;
        inner_next   = inner_reg;
        outer_next   = outer_reg;
        frame_next   = frame_reg;
        stacked_next = stacked_reg;
        dot_next     = dot_reg;

        if (is_last)
        begin
            // Load the first frame of the following effect
            effect_next  = effect_succ;
            inner_next   = 5'd0;
            outer_next   = 5'd0;
            stacked_next = '0;
            dot_next     = W'(1);
            unique case (effect_succ)
                les_pkg::EFF_BLINK_ALL:    frame_next = les_pkg::ROW_MASK;
                les_pkg::EFF_FILL_RIGHT:   frame_next = W'(1);
                les_pkg::EFF_CLEAR_RIGHT:  frame_next = les_pkg::ROW_MASK >> 1;
                les_pkg::EFF_FILL_LEFT:    frame_next = les_pkg::TOP_BIT;
                les_pkg::EFF_CLEAR_LEFT:   frame_next = (les_pkg::ROW_MASK << 1) & les_pkg::ROW_MASK;
                les_pkg::EFF_ALTERNATE:    frame_next = les_pkg::ALT_BITS;
                les_pkg::EFF_BLINK_HALVES: frame_next = les_pkg::HIGH_HALF;
                les_pkg::EFF_STACK_UP:     frame_next = W'(1);
                les_pkg::EFF_STACK_DOWN:
                begin
                    dot_next   = les_pkg::TOP_BIT;
                    frame_next = les_pkg::TOP_BIT;
                end
                default:                   frame_next = les_pkg::HIGH_HALF;
            endcase
        end
        else
        begin
            unique case (effect_reg)
                les_pkg::EFF_BLINK_ALL, les_pkg::EFF_ALTERNATE, les_pkg::EFF_BLINK_HALVES:
                begin
                    frame_next = ~frame_reg & les_pkg::ROW_MASK;
                    inner_next = inner_inc;
                end
                les_pkg::EFF_FILL_RIGHT:
                begin
                    frame_next = ((frame_reg << 1) | W'(1)) & les_pkg::ROW_MASK;
                    inner_next = inner_inc;
                end
                les_pkg::EFF_CLEAR_RIGHT:
                begin
                    frame_next = frame_reg >> 1;
                    inner_next = inner_inc;
                end
                les_pkg::EFF_FILL_LEFT:
                begin
                    frame_next = (frame_reg >> 1) | les_pkg::TOP_BIT;
                    inner_next = inner_inc;
                end
                les_pkg::EFF_CLEAR_LEFT:
                begin
                    frame_next = (frame_reg << 1) & les_pkg::ROW_MASK;
                    inner_next = inner_inc;
                end
                les_pkg::EFF_STACK_UP, les_pkg::EFF_STACK_DOWN:
                begin
                    if (inner_reg < les_pkg::LAST_POS)
                    begin
                        inner_next = inner_inc;
                        dot_next   = dot_adv;
                    end
                    else
                    begin
                        // Dot reached the stack: freeze it and launch a new one
                        stacked_next = frame_reg;
                        outer_next   = outer_inc;
                        inner_next   = outer_inc;
                        dot_next     = (effect_reg == les_pkg::EFF_STACK_UP) ? W'(1)
                                                                             : les_pkg::TOP_BIT;
                    end
                    frame_next = (dot_next | stacked_next) & les_pkg::ROW_MASK;
                end
                default:
                begin
                    if (blink_last)
                    begin
                        outer_next = 5'd1;
                        inner_next = 5'd0;
                        frame_next = les_pkg::LOW_HALF;
                    end
                    else
                    begin
                        inner_next = inner_inc;
                        if (inner_inc[0])
                            frame_next = '0;
                        else
                            frame_next = (outer_reg != 5'd0) ? les_pkg::LOW_HALF
                                                             : les_pkg::HIGH_HALF;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_reg  <= les_pkg::EFF_BLINK_ALL;
            inner_reg   <= 5'd0;
            outer_reg   <= 5'd0;
            frame_reg   <= les_pkg::ROW_MASK;
            stacked_reg <= '0;
            dot_reg     <= W'(1);
        end
        else if (step && advance)
        begin
            effect_reg  <= effect_next;
            inner_reg   <= inner_next;
            outer_reg   <= outer_next;
            frame_reg   <= frame_next;
            stacked_reg <= stacked_next;
            dot_reg     <= dot_next;
        end
    end

    always_comb
    begin
        result.led_pattern   = 16'(32'(frame_reg));
        result.effect_number = (effect_reg > les_pkg::EFF_SPLIT_BLINK) ? les_pkg::EFF_SPLIT_BLINK
                                                                       : effect_reg;
        result.cycle_end     = (effect_reg == les_pkg::EFF_SPLIT_BLINK) && is_last;
    end

    `ASSERT_NEXT(a_wrap_restarts, step && advance && result.cycle_end, (effect_reg == les_pkg::EFF_BLINK_ALL) && (frame_reg == les_pkg::ROW_MASK))
    `ASSERT_NEXT(a_hold_frame, !(step && advance), $stable(frame_reg) && $stable(effect_reg))
    `ASSERT_SAME(a_stack_order, (effect_reg == les_pkg::EFF_STACK_UP) || (effect_reg == les_pkg::EFF_STACK_DOWN), inner_reg >= outer_reg)

endmodule

### hdl/led_effect_sequencer_16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_effect_sequencer_16
// Sixteen-LED chaser: each tick request yields the current frame of a fixed
// ten-effect sequence and optionally steps to the next frame.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake           Payload
//  tick      in    valid/ready         advance
//  frame     out   valid/ready         led_pattern, effect_number, cycle_end
//  APB       in    psel/penable        blink_frames at byte address 0
//
//  One tick request is taken per cycle while the output register is empty
//  or draining; its frame appears in the output register on the next cycle.
//  Reset (rst_n low) restores effect 0, all LEDs on, blink_frames = 10.
//  A stalled frame holds in the output register; a new tick is still taken
//  in the cycle that frame is drained.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_effect_sequencer_16
(
    input  logic          clk,
    input  logic          rst_n,
    les_tick_if.sink      tick,
    les_frame_if.source   frame,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [4:0]       blink_reg;
    logic             out_valid_reg;
    les_pkg::frame_t  out_reg;
    les_pkg::frame_t  gen_result;
    logic             take_tick;
    logic             cfg_write;

    // ---- Configuration port -------------------------------------------------
    // Decode on the word select bit only; byte lanes within the word alias.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == les_pkg::REG_BLINK_FRAMES) ? 32'(blink_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blink_reg <= les_pkg::BLINK_RESET;
        else if (cfg_write && (paddr[2] == les_pkg::REG_BLINK_FRAMES))
            blink_reg <= pwdata[4:0];
    end

    // ---- Tick acceptance ----------------------------------------------------
    // Take a tick whenever the output register is empty or draining now.
    assign tick.ready = !out_valid_reg || frame.ready;
    assign take_tick  = tick.valid && tick.ready;

    les_frame_gen u_frame_gen
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .blink_frames (blink_reg),
        .step         (take_tick),
        .advance      (tick.advance),
        .result       (gen_result)
    );

    // ---- Output register ----------------------------------------------------
    // Capture the frame shown for this tick; drop valid once it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take_tick)
            out_valid_reg <= 1'b1;
        else if (frame.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take_tick)
            out_reg <= gen_result;
    end

    assign frame.valid         = out_valid_reg;
    assign frame.led_pattern   = out_reg.led_pattern;
    assign frame.effect_number = out_reg.effect_number;
    assign frame.cycle_end     = out_reg.cycle_end;

    `ASSERT_NEXT(a_tick_fills_output, take_tick, out_valid_reg)
    `ASSERT_SAME(a_effect_in_range, out_valid_reg, out_reg.effect_number <= les_pkg::EFF_SPLIT_BLINK)

endmodule

### tb/les_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// les_frame_checker
// Watches the tick, frame and APB ports of the LED effect sequencer, predicts
// the frame for every accepted tick request and compares it field by field.
// ----------------------------------------------------------------------------
module les_frame_checker
    import les_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    les_tick_if         tick,
    les_frame_if        frame,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          fail_count,
    output int          due_count,
    output int          frames_checked,
    output int          wraps_seen
);

    localparam logic [2:0]  BLINK_ADDR    = {REG_BLINK_FRAMES, 2'b00};
    localparam logic [4:0]  BLINK_DEFAULT = 5'd10;
    localparam logic [15:0] ALL_ON        = 16'hFFFF;
    localparam logic [15:0] LEFT_LED      = 16'h8000;
    localparam logic [15:0] UPPER_HALF    = 16'hFF00;
    localparam logic [15:0] LOWER_HALF    = 16'h00FF;
    localparam logic [15:0] ALT_PATTERN   = 16'hAAAA;
    localparam int          LAST_STEP     = 15;

    // Shadow of the sequencer state
    logic [3:0]  effect;
    logic [4:0]  inner;
    logic [4:0]  outer;
    logic [15:0] shown;
    logic [15:0] stacked;
    logic [15:0] dot;
    logic [4:0]  blink_len;

    frame_t frames_due[$];
    int     mismatches;
    int     checked;
    int     wraps;

    function automatic int blink_count();
        return (blink_len == 5'd0) ? 1 : int'(blink_len);
    endfunction

    function automatic void begin_effect(input logic [3:0] e);
        effect  = e;
        inner   = 5'd0;
        outer   = 5'd0;
        stacked = 16'h0000;
        dot     = 16'h0001;
        case (e)
            EFF_BLINK_ALL:    shown = ALL_ON;
            EFF_FILL_RIGHT:   shown = 16'h0001;
            EFF_CLEAR_RIGHT:  shown = ALL_ON >> 1;
            EFF_FILL_LEFT:    shown = LEFT_LED;
            EFF_CLEAR_LEFT:   shown = ALL_ON << 1;
            EFF_ALTERNATE:    shown = ALT_PATTERN;
            EFF_BLINK_HALVES: shown = UPPER_HALF;
            EFF_STACK_UP:     shown = 16'h0001;
            EFF_STACK_DOWN:
            begin
                dot   = LEFT_LED;
                shown = LEFT_LED;
            end
            default:          shown = UPPER_HALF;
        endcase
    endfunction

    function automatic bit last_frame();
        case (effect)
            EFF_BLINK_ALL, EFF_ALTERNATE, EFF_BLINK_HALVES:
                return int'(inner) + 1 >= blink_count();
            EFF_FILL_RIGHT, EFF_CLEAR_RIGHT, EFF_FILL_LEFT, EFF_CLEAR_LEFT:
                return int'(inner) >= LAST_STEP;
            EFF_STACK_UP, EFF_STACK_DOWN:
                return int'(outer) >= LAST_STEP && int'(inner) >= LAST_STEP;
            EFF_SPLIT_BLINK:
                return outer != 5'd0 && int'(inner) + 1 >= blink_count();
            default:
                return 1'b1;
        endcase
    endfunction

    function automatic void step_frame();
        if (last_frame())
        begin
            begin_effect((effect >= EFF_SPLIT_BLINK) ? EFF_BLINK_ALL : effect + 4'd1);
            return;
        end
        case (effect)
            EFF_BLINK_ALL, EFF_ALTERNATE, EFF_BLINK_HALVES:
            begin
                shown = ~shown;
                inner = inner + 5'd1;
            end
            EFF_FILL_RIGHT:
            begin
                shown = {shown[14:0], 1'b1};
                inner = inner + 5'd1;
            end
            EFF_CLEAR_RIGHT:
            begin
                shown = shown >> 1;
                inner = inner + 5'd1;
            end
            EFF_FILL_LEFT:
            begin
                shown = (shown >> 1) | LEFT_LED;
                inner = inner + 5'd1;
            end
            EFF_CLEAR_LEFT:
            begin
                shown = shown << 1;
                inner = inner + 5'd1;
            end
            EFF_STACK_UP, EFF_STACK_DOWN:
            begin
                if (int'(inner) < LAST_STEP)
                begin
                    inner = inner + 5'd1;
                    dot   = (effect == EFF_STACK_UP) ? dot << 1 : dot >> 1;
                end
                else
                begin
                    // the dot has landed: keep it and launch a fresh one
                    stacked = shown;
                    outer   = outer + 5'd1;
                    inner   = outer;
                    dot     = (effect == EFF_STACK_UP) ? 16'h0001 : LEFT_LED;
                end
                shown = dot | stacked;
            end
            default:
            begin
                if (int'(inner) + 1 >= blink_count())
                begin
                    outer = 5'd1;
                    inner = 5'd0;
                    shown = LOWER_HALF;
                end
                else
                begin
                    inner = inner + 5'd1;
                    if (inner[0])
                        shown = 16'h0000;
                    else
                        shown = (outer != 5'd0) ? LOWER_HALF : UPPER_HALF;
                end
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_t want;
        if (!rst_n)
        begin
            blink_len = BLINK_DEFAULT;
            begin_effect(EFF_BLINK_ALL);
            frames_due.delete();
            mismatches = 0;
            checked    = 0;
            wraps      = 0;
        end
        else
        begin
            if (frame.valid && frame.ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("frame with no tick request pending: led_pattern %h",
                           frame.led_pattern);
                    mismatches++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (frame.led_pattern !== want.led_pattern)
                    begin
                        $error("led_pattern: expected %h, got %h",
                               want.led_pattern, frame.led_pattern);
                        mismatches++;
                    end
                    if (frame.effect_number !== want.effect_number)
                    begin
                        $error("effect_number: expected %0d, got %0d",
                               want.effect_number, frame.effect_number);
                        mismatches++;
                    end
                    if (frame.cycle_end !== want.cycle_end)
                    begin
                        $error("cycle_end: expected %b, got %b",
                               want.cycle_end, frame.cycle_end);
                        mismatches++;
                    end
                    checked++;
                    if (want.cycle_end)
                        wraps++;
                end
            end

            if (tick.valid && tick.ready)
            begin
                want.led_pattern   = shown;
                want.effect_number = (effect > EFF_SPLIT_BLINK) ? EFF_SPLIT_BLINK : effect;
                want.cycle_end     = (effect == EFF_SPLIT_BLINK) && last_frame();
                frames_due.push_back(want);
                if (tick.advance)
                    step_frame();
            end

            if (psel && penable && pready && paddr == BLINK_ADDR)
            begin
                if (pwrite)
                    blink_len = pwdata[4:0];
                else if (prdata[4:0] !== blink_len)
                begin
                    $error("blink_frames: expected %0d, got %0d", blink_len, prdata[4:0]);
                    mismatches++;
                end
            end
        end
        fail_count     <= mismatches;
        due_count      <= frames_due.size();
        frames_checked <= checked;
        wraps_seen     <= wraps;
    end

endmodule

### tb/tb_led_effect_sequencer_16.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_effect_sequencer_16
// Drives tick requests and blink-length writes into the LED effect sequencer
// under random gaps and back-pressure; a checker beside the block predicts
// and compares every frame, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_led_effect_sequencer_16;
    import les_pkg::*;

    localparam logic [2:0] BLINK_ADDR   = {REG_BLINK_FRAMES, 2'b00};
    localparam int         RANDOM_TICKS = 1600;
    localparam int         LONG_HOLD    = 60;
    // Longest legal silence is the long receiver hold; allow many times that.
    localparam int         STALL_LIMIT  = 1000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    les_tick_if  tick ();
    les_frame_if frame ();

    int fail_count;
    int due_count;
    int frames_checked;
    int wraps_seen;

    // Stimulus state; rx_hold and quiet_rx are shared with the frame sink
    int rx_hold;
    bit quiet_tx;
    bit quiet_rx;
    int settings_applied;

    led_effect_sequencer_16 u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick),
        .frame   (frame),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    les_frame_checker u_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick),
        .frame          (frame),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .due_count      (due_count),
        .frames_checked (frames_checked),
        .wraps_seen     (wraps_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one tick request after a random gap and hold it until taken.
    // Called at a clock edge; returns at the edge that accepted the request.
    task automatic send_tick(input logic adv);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            // drop valid for the gap, raise it again on a later edge
            tick.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick.valid   <= 1'b1;
        tick.advance <= adv;
        do
            @(posedge clk);
        while (!(tick.valid && tick.ready));
    endtask

    // Drop valid and wait until every predicted frame has been drained.
    // The outstanding count is registered in the checker, so sample after an edge.
    task automatic drain_frames();
        tick.valid <= 1'b0;
        do
            @(posedge clk);
        while (due_count != 0);
    endtask

    // One APB transfer: setup, access, then idle with psel low, so back-to-back
    // calls never assign psel twice in the same step.
    task automatic apb_access(input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= BLINK_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Change the blink length only with the block idle: drain, let the output
    // register settle, write with random upper bits, read back.
    task automatic set_blink(input logic [4:0] len);
        logic [31:0] word;
        drain_frames();
        repeat (2) @(posedge clk);
        word      = $urandom();
        word[4:0] = len;
        apb_access(1'b1, word);
        apb_access(1'b0, $urandom());
        settings_applied++;
    endtask

    // Frame sink: after each accepted frame draw a random stall (none while
    // quiet_rx is set); a long hold requested by the stimulus takes priority.
    initial
    begin : frame_sink
        int stall;
        stall = 0;
        frame.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (frame.valid && frame.ready)
                stall = quiet_rx ? 0 : $urandom_range(0, 3);
            if (rx_hold > 0)
            begin
                rx_hold--;
                frame.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                frame.ready <= 1'b0;
            end
            else
                frame.ready <= 1'b1;
        end
    end

    // Watchdog: end the run if no handshake of any kind happens for too long.
    initial
    begin : watchdog
        int silent;
        silent = 0;
        forever
        begin
            @(posedge clk);
            if ((tick.valid && tick.ready) || (frame.valid && frame.ready) ||
                (psel && penable))
                silent = 0;
            else
                silent++;
            if (silent >= STALL_LIMIT)
            begin
                $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int         phase;
        int         span;
        int         i;
        int         random_sent;
        logic [4:0] len;

        // Hold every input at a known value from time zero
        rst_n            = 1'b0;
        tick.valid      <= 1'b0;
        tick.advance    <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= BLINK_ADDR;
        pwdata          <= 32'd0;
        rx_hold          = 0;
        quiet_tx         = 1'b0;
        quiet_rx         = 1'b0;
        settings_applied = 0;
        random_sent      = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset frame held twice, then stepped, under the reset
        // blink length of ten.
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);

        // Blink length zero acts as one; effect 0 is already past that
        // length, so the next advance moves on to fill-from-the-right.
        set_blink(5'd0);
        repeat (6) send_tick(1'b1);
        send_tick(1'b0);

        // Largest field value, then the smallest nonzero one
        set_blink(5'd31);
        repeat (4) send_tick(1'b1);
        set_blink(5'd1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);

        // Random phases: each picks a blink length and idling style, then
        // sends mostly advancing ticks so the sequence wraps several times.
        phase = 0;
        while (random_sent < RANDOM_TICKS)
        begin
            case (phase)
                0:       len = 5'd2;
                1:       len = 5'd30;
                default:
                begin
                    case ($urandom_range(0, 5))
                        0:       len = 5'd0;
                        1:       len = 5'd1;
                        2:       len = 5'd2;
                        3:       len = 5'd30;
                        4:       len = 5'd31;
                        default: len = 5'($urandom_range(2, 30));
                    endcase
                end
            endcase
            set_blink(len);

            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            span     = $urandom_range(60, 240);

            // Long receiver hold while the sender keeps offering: the output
            // register fills and the block must stall its tick input.
            if (phase == 1)
            begin
                quiet_tx = 1'b1;
                rx_hold  = LONG_HOLD;
            end

            for (i = 0; i < span && random_sent < RANDOM_TICKS; i++)
            begin
                // Sender pause: stop mid-phase until every frame is out
                if (phase == 2 && i == span / 2)
                    drain_frames();
                send_tick(logic'($urandom_range(0, 7) != 0));
                random_sent++;
            end
            phase++;
        end

        // Let the last frames drain, then give the pipeline time to settle
        drain_frames();
        repeat (4) @(posedge clk);

        $display("Checked %0d frames across %0d blink lengths; the ten-effect sequence",
                 frames_checked, settings_applied);
        $display("wrapped %0d times, under random gaps, stalls and one long hold.",
                 wraps_seen);
        if (fail_count == 0 && due_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
